>>> hdl/dzoc_pkg.sv
// Shared types and constants for the damage zone object clipper.
package dzoc_pkg;

  localparam int MAX_WINDOWS_DEF = 16;
  localparam int MAX_PIECES      = 16;
  localparam int COORD_W         = 17;
  localparam int DIM_W           = 15;
  localparam int CNT_W           = 5;
  localparam int TAG_OUT_W       = 4;

  localparam logic [DIM_W-1:0] CANVAS_W_RST = 15'd1024;
  localparam logic [DIM_W-1:0] CANVAS_H_RST = 15'd768;
  localparam logic [CNT_W-1:0] OBJ_CNT_RST  = 5'd0;

  localparam logic [1:0] REG_CANVAS_W = 2'd0;
  localparam logic [1:0] REG_CANVAS_H = 2'd1;
  localparam logic [1:0] REG_OBJ_CNT  = 2'd2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_ZONE = 1'b1;

  // One window table entry; right and bottom edges are stored precomputed.
  typedef struct packed {
    logic [15:0]        x;
    logic [15:0]        y;
    logic [COORD_W-1:0] r;
    logic [COORD_W-1:0] b;
    logic               vis;
    logic               cur;
  } win_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic entry_write;
    logic zone_load;
    logic rd_en;
    logic finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pipe_busy;
  } dp_status_t;

endpackage

>>> hdl/dzoc_ctrl.sv
// Controller state machine: accepts items and sequences the table scan.
module dzoc_ctrl #(
  parameter int MAX_WINDOWS = dzoc_pkg::MAX_WINDOWS_DEF,
  localparam int LIM_W = ($clog2(MAX_WINDOWS + 1) > 5) ? $clog2(MAX_WINDOWS + 1) : 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         cmd,
  input  logic                         already_assigned,
  input  logic [dzoc_pkg::CNT_W-1:0]   object_count,
  input  dzoc_pkg::dp_status_t         status,
  output logic                         busy,
  output dzoc_pkg::dp_cmd_t            ctl,
  output logic [LIM_W-1:0]             rd_tag
);
  import dzoc_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]       state, state_next;
  logic [LIM_W-1:0] idx, idx_next;
  logic [LIM_W-1:0] limit, limit_next;
  logic [LIM_W-1:0] obj_ext, lim_in;
  logic             accept;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign obj_ext = LIM_W'(object_count);
  assign lim_in  = (obj_ext > LIM_W'(MAX_WINDOWS)) ? LIM_W'(MAX_WINDOWS) : obj_ext;
  assign rd_tag  = idx;

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    limit_next      = limit;
    ctl.entry_write = accept && (cmd == CMD_LOAD);
    ctl.zone_load   = accept && (cmd == CMD_ZONE);
    ctl.rd_en       = 1'b0;
    ctl.finish      = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept && (cmd == CMD_ZONE)) begin
          idx_next   = '0;
          limit_next = lim_in;
          if (already_assigned || (lim_in == '0)) begin
            state_next = S_DRAIN;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        ctl.rd_en = 1'b1;
        idx_next  = idx + 1'b1;
        if (idx == limit - 1'b1) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status.pipe_busy) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      limit <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      limit <= limit_next;
    end
  end

endmodule

>>> hdl/dzoc_dpath.sv
// Datapath: window table, intersect and clip pipeline, pending piece and output register.
module dzoc_dpath #(
  parameter int MAX_WINDOWS = dzoc_pkg::MAX_WINDOWS_DEF,
  localparam int LIM_W = ($clog2(MAX_WINDOWS + 1) > 5) ? $clog2(MAX_WINDOWS + 1) : 5,
  localparam int IDX_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  dzoc_pkg::dp_cmd_t              ctl,
  input  logic [LIM_W-1:0]               rd_tag,
  output dzoc_pkg::dp_status_t           status,
  input  logic [3:0]                     entry_index,
  input  logic signed [15:0]             rect_x,
  input  logic signed [15:0]             rect_y,
  input  logic [dzoc_pkg::DIM_W-1:0]     rect_width,
  input  logic [dzoc_pkg::DIM_W-1:0]     rect_height,
  input  logic                           is_visible,
  input  logic                           is_cursor,
  input  logic [dzoc_pkg::DIM_W-1:0]     canvas_width,
  input  logic [dzoc_pkg::DIM_W-1:0]     canvas_height,
  output logic                           strobe,
  output logic [dzoc_pkg::DIM_W-1:0]     piece_x,
  output logic [dzoc_pkg::DIM_W-1:0]     piece_y,
  output logic [dzoc_pkg::DIM_W-1:0]     piece_width,
  output logic [dzoc_pkg::DIM_W-1:0]     piece_height,
  output logic [dzoc_pkg::TAG_OUT_W-1:0] window_index,
  output logic                           piece_valid,
  output logic                           last_piece
);
  import dzoc_pkg::*;

  // Window table.
  win_t             mem [MAX_WINDOWS];
  win_t             wr_entry;
  logic [LIM_W-1:0] ent_ext;
  logic             wr_ok;

  // Zone registers.
  logic signed [COORD_W-1:0] zx, zy, zr, zb;

  // Stage A: table read.
  win_t             rd_q;
  logic             va;
  logic [LIM_W-1:0] tag_a;

  // Stage B: intersection.
  logic signed [COORD_W-1:0] ex, ey, er, eb;
  logic signed [COORD_W-1:0] x0_n, y0_n, x1_n, y1_n;
  logic                      hit;
  logic signed [COORD_W-1:0] x0_b, y0_b, x1_b, y1_b;
  logic                      vb;
  logic [LIM_W-1:0]          tag_b;

  // Stage C: canvas clip.
  logic signed [COORD_W-1:0] cw, ch;
  logic signed [COORD_W-1:0] x0c, y0c, x1c, y1c;
  logic                      keep;
  logic [DIM_W-1:0]          x0_c, y0_c, x1_c, y1_c;
  logic                      vc;
  logic [TAG_OUT_W-1:0]      tag_c;

  // Pending piece, held until it is known whether it is the last one.
  logic [DIM_W-1:0]     px0, py0, px1, py1;
  logic [TAG_OUT_W-1:0] ptag;
  logic                 pend_full;
  logic [CNT_W-1:0]     pcnt;
  logic                 cand;

  assign ent_ext = LIM_W'(entry_index);
  assign wr_ok   = ent_ext < LIM_W'(MAX_WINDOWS);

  always_comb begin
    wr_entry.x   = rect_x;
    wr_entry.y   = rect_y;
    wr_entry.r   = {rect_x[15], rect_x} + {2'b00, rect_width};
    wr_entry.b   = {rect_y[15], rect_y} + {2'b00, rect_height};
    wr_entry.vis = is_visible;
    wr_entry.cur = is_cursor;
  end

  always_ff @(posedge clk) begin
    if (ctl.entry_write && wr_ok) begin
      mem[ent_ext[IDX_W-1:0]] <= wr_entry;
    end
    if (ctl.rd_en) begin
      rd_q <= mem[rd_tag[IDX_W-1:0]];
    end
    tag_a <= rd_tag;
  end

  always_ff @(posedge clk) begin
    if (ctl.zone_load) begin
      zx <= $signed({rect_x[15], rect_x});
      zy <= $signed({rect_y[15], rect_y});
      zr <= $signed({rect_x[15], rect_x} + {2'b00, rect_width});
      zb <= $signed({rect_y[15], rect_y} + {2'b00, rect_height});
    end
  end

  always_comb begin
    ex   = $signed({rd_q.x[15], rd_q.x});
    ey   = $signed({rd_q.y[15], rd_q.y});
    er   = $signed(rd_q.r);
    eb   = $signed(rd_q.b);
    // Edges that only touch the zone still count as a hit.
    hit  = rd_q.vis && !rd_q.cur && !(er < zx) && !(eb < zy) && !(ex > zr) && !(ey > zb);
    x0_n = (ex > zx) ? ex : zx;
    y0_n = (ey > zy) ? ey : zy;
    x1_n = (er < zr) ? er : zr;
    y1_n = (eb < zb) ? eb : zb;
  end

  always_ff @(posedge clk) begin
    x0_b  <= x0_n;
    y0_b  <= y0_n;
    x1_b  <= x1_n;
    y1_b  <= y1_n;
    tag_b <= tag_a;
  end

  always_comb begin
    cw   = $signed({2'b00, canvas_width});
    ch   = $signed({2'b00, canvas_height});
    keep = !(x0_b >= cw) && !(y0_b >= ch) && !(x1_b < 0) && !(y1_b < 0);
    x0c  = (x0_b < 0) ? '0 : x0_b;
    y0c  = (y0_b < 0) ? '0 : y0_b;
    x1c  = (x1_b > cw) ? cw : x1_b;
    y1c  = (y1_b > ch) ? ch : y1_b;
  end

  always_ff @(posedge clk) begin
    x0_c  <= x0c[DIM_W-1:0];
    y0_c  <= y0c[DIM_W-1:0];
    x1_c  <= x1c[DIM_W-1:0];
    y1_c  <= y1c[DIM_W-1:0];
    tag_c <= tag_b[TAG_OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      va <= ctl.rd_en;
      vb <= va && hit;
      vc <= vb && keep;
    end
  end

  // Pieces beyond the cap are ignored; the capped piece ends the zone.
  assign cand = vc && (pcnt < CNT_W'(MAX_PIECES));

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_full <= 1'b0;
      pcnt      <= '0;
    end else if (ctl.zone_load) begin
      pend_full <= 1'b0;
      pcnt      <= '0;
    end else if (cand) begin
      pend_full <= 1'b1;
      pcnt      <= pcnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cand) begin
      px0  <= x0_c;
      py0  <= y0_c;
      px1  <= x1_c;
      py1  <= y1_c;
      ptag <= tag_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctl.finish || (cand && pend_full);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish && !pend_full) begin
      piece_x      <= '0;
      piece_y      <= '0;
      piece_width  <= '0;
      piece_height <= '0;
      window_index <= '0;
      piece_valid  <= 1'b0;
      last_piece   <= 1'b1;
    end else begin
      piece_x      <= px0;
      piece_y      <= py0;
      piece_width  <= px1 - px0;
      piece_height <= py1 - py0;
      window_index <= ptag;
      piece_valid  <= 1'b1;
      last_piece   <= ctl.finish;
    end
  end

  assign status.pipe_busy = va || vb || vc;

endmodule

>>> hdl/damage_zone_object_clipper_unit.sv
// Top level of the damage zone object clipper: configuration registers and unit wiring.
//
//  channel   | handshake                  | words
//  ----------+----------------------------+---------------------------------------------
//  item in   | start, busy                | cmd, entry_index, rect_*, flags, assigned
//  result    | strobe (one cycle, no stall)| piece_*, window_index, piece_valid, last_piece
//  config    | cfg_valid, cfg_ready       | cfg_index, cfg_data
//
// A load word is taken at once and writes one table entry; busy stays low.
// A zone word scans the window table one entry per cycle through a three-stage
// read, intersect and clip pipeline over min(object_count, MAX_WINDOWS) entries
// and holds busy until the pipeline drains; an assigned zone skips the scan.
// Reset is synchronous and clears the controller, pipeline valids and the
// configuration registers; the table contents stay undefined until written.
// Results cannot be stalled: each one is shown for exactly one cycle.
module damage_zone_object_clipper_unit #(
  parameter int MAX_WINDOWS = dzoc_pkg::MAX_WINDOWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           cmd,
  input  logic [3:0]                     entry_index,
  input  logic signed [15:0]             rect_x,
  input  logic signed [15:0]             rect_y,
  input  logic [dzoc_pkg::DIM_W-1:0]     rect_width,
  input  logic [dzoc_pkg::DIM_W-1:0]     rect_height,
  input  logic                           is_visible,
  input  logic                           is_cursor,
  input  logic                           already_assigned,
  output logic                           strobe,
  output logic [dzoc_pkg::DIM_W-1:0]     piece_x,
  output logic [dzoc_pkg::DIM_W-1:0]     piece_y,
  output logic [dzoc_pkg::DIM_W-1:0]     piece_width,
  output logic [dzoc_pkg::DIM_W-1:0]     piece_height,
  output logic [dzoc_pkg::TAG_OUT_W-1:0] window_index,
  output logic                           piece_valid,
  output logic                           last_piece,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [dzoc_pkg::DIM_W-1:0]     cfg_data
);
  import dzoc_pkg::*;

  localparam int LIM_W = ($clog2(MAX_WINDOWS + 1) > 5) ? $clog2(MAX_WINDOWS + 1) : 5;

  logic [DIM_W-1:0] canvas_width, canvas_height;
  logic [CNT_W-1:0] object_count;
  dp_cmd_t          ctl;
  dp_status_t       status;
  logic [LIM_W-1:0] rd_tag;

  // The register file is always ready; writes to an unused index are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= CANVAS_W_RST;
      canvas_height <= CANVAS_H_RST;
      object_count  <= OBJ_CNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CANVAS_W: canvas_width  <= cfg_data;
        REG_CANVAS_H: canvas_height <= cfg_data;
        REG_OBJ_CNT:  object_count  <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The controller walks the table addresses and decides when the zone ends.
  dzoc_ctrl #(
    .MAX_WINDOWS(MAX_WINDOWS)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .cmd              (cmd),
    .already_assigned (already_assigned),
    .object_count     (object_count),
    .status           (status),
    .busy             (busy),
    .ctl              (ctl),
    .rd_tag           (rd_tag)
  );

  // The datapath holds the table, clips each hit and holds back one piece so
  // that the final piece of a zone can carry last_piece.
  dzoc_dpath #(
    .MAX_WINDOWS(MAX_WINDOWS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .rd_tag        (rd_tag),
    .status        (status),
    .entry_index   (entry_index),
    .rect_x        (rect_x),
    .rect_y        (rect_y),
    .rect_width    (rect_width),
    .rect_height   (rect_height),
    .is_visible    (is_visible),
    .is_cursor     (is_cursor),
    .canvas_width  (canvas_width),
    .canvas_height (canvas_height),
    .strobe        (strobe),
    .piece_x       (piece_x),
    .piece_y       (piece_y),
    .piece_width   (piece_width),
    .piece_height  (piece_height),
    .window_index  (window_index),
    .piece_valid   (piece_valid),
    .last_piece    (last_piece)
  );

  // A result only follows a cycle in which a zone was in progress.
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result word without a zone in progress");

  // The empty marker always closes its zone.
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && !piece_valid) |-> last_piece)
    else $error("empty result word not marked last");

  // Once the last word of a zone is out, the unit is free again.
  a_last_frees_unit: assert property (@(posedge clk) disable iff (rst)
    (strobe && last_piece) |-> !busy)
    else $error("unit still busy after last result word");

  // A table load completes in the cycle it is taken.
  a_load_no_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd == CMD_LOAD)) |=> (!busy && !strobe))
    else $error("table load held the unit");

endmodule

>>> bench/damage_zone_checker.sv
// Checker for the damage zone clipper: tracks table and registers, predicts pieces, compares.
module damage_zone_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic                       cmd,
  input  logic [3:0]                 entry_index,
  input  logic signed [15:0]         rect_x,
  input  logic signed [15:0]         rect_y,
  input  logic [dzoc_pkg::DIM_W-1:0] rect_width,
  input  logic [dzoc_pkg::DIM_W-1:0] rect_height,
  input  logic                       is_visible,
  input  logic                       is_cursor,
  input  logic                       already_assigned,
  input  logic                       strobe,
  input  logic [dzoc_pkg::DIM_W-1:0] piece_x,
  input  logic [dzoc_pkg::DIM_W-1:0] piece_y,
  input  logic [dzoc_pkg::DIM_W-1:0] piece_width,
  input  logic [dzoc_pkg::DIM_W-1:0] piece_height,
  input  logic [3:0]                 window_index,
  input  logic                       piece_valid,
  input  logic                       last_piece,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [dzoc_pkg::DIM_W-1:0] cfg_data,
  output int                         fail_count,
  output int                         pending,
  output int                         pieces_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import dzoc_pkg::*;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    logic               vis;
    logic               cur;
  } window_rec_t;

  typedef struct packed {
    logic [DIM_W-1:0] x;
    logic [DIM_W-1:0] y;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [3:0]       win;
    logic             valid;
    logic             last;
  } piece_t;

  window_rec_t      window_tab [MAX_WINDOWS_DEF];
  logic [DIM_W-1:0] canvas_w_q = CANVAS_W_RST;
  logic [DIM_W-1:0] canvas_h_q = CANVAS_H_RST;
  logic [CNT_W-1:0] obj_count_q = OBJ_CNT_RST;
  piece_t           expected_pieces [$];

  initial begin
    fail_count = 0;
    pending = 0;
    pieces_checked = 0;
    foreach (window_tab[k]) window_tab[k] = '{default: '0};
  end

  // Cuts the zone against each live window below the object count, in index order, and queues the pieces.
  function automatic void predict_zone(int zx, int zy, int zw, int zh, logic assigned);
    int     scan_len, cw, ch, ex, ey, er, eb, x0, y0, x1, y1, produced;
    piece_t p;
    piece_t held;
    bit     have_held;
    cw = int'(canvas_w_q);
    ch = int'(canvas_h_q);
    scan_len = (obj_count_q > MAX_WINDOWS_DEF) ? MAX_WINDOWS_DEF : int'(obj_count_q);
    produced = 0;
    have_held = 1'b0;
    held = '0;
    if (!assigned) begin
      for (int j = 0; j < scan_len && produced < MAX_PIECES; j++) begin
        if (window_tab[j].cur || !window_tab[j].vis) continue;
        ex = window_tab[j].x;
        ey = window_tab[j].y;
        er = ex + int'(window_tab[j].w);
        eb = ey + int'(window_tab[j].h);
        if (er < zx || eb < zy || ex > zx + zw || ey > zy + zh) continue;
        x0 = (zx > ex) ? zx : ex;
        y0 = (zy > ey) ? zy : ey;
        x1 = (zx + zw < er) ? zx + zw : er;
        y1 = (zy + zh < eb) ? zy + zh : eb;
        if (x0 > cw - 1 || y0 > ch - 1 || x1 < 0 || y1 < 0) continue;
        if (x0 < 0) x0 = 0;
        if (y0 < 0) y0 = 0;
        if (x1 > cw) x1 = cw;
        if (y1 > ch) y1 = ch;
        p.x = 15'(x0);
        p.y = 15'(y0);
        p.w = 15'(x1 - x0);
        p.h = 15'(y1 - y0);
        p.win = 4'(j);
        p.valid = 1'b1;
        p.last = 1'b0;
        if (have_held) expected_pieces.push_back(held);
        held = p;
        have_held = 1'b1;
        produced++;
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      expected_pieces.push_back(held);
    end else begin
      p = '0;
      p.last = 1'b1;
      expected_pieces.push_back(p);
    end
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    piece_t want;
    if (rst) begin
      canvas_w_q = CANVAS_W_RST;
      canvas_h_q = CANVAS_H_RST;
      obj_count_q = OBJ_CNT_RST;
      expected_pieces.delete();
    end else begin
      if (strobe) begin
        if (expected_pieces.size() == 0) begin
          $error("result word with no piece expected: x %0d y %0d w %0d h %0d window %0d",
                 piece_x, piece_y, piece_width, piece_height, window_index);
          fail_count++;
        end else begin
          want = expected_pieces.pop_front();
          check_field("piece_x", want.x, piece_x);
          check_field("piece_y", want.y, piece_y);
          check_field("piece_width", want.w, piece_width);
          check_field("piece_height", want.h, piece_height);
          check_field("window_index", want.win, window_index);
          check_field("piece_valid", want.valid, piece_valid);
          check_field("last_piece", want.last, last_piece);
          pieces_checked++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CANVAS_W: canvas_w_q = cfg_data;
          REG_CANVAS_H: canvas_h_q = cfg_data;
          REG_OBJ_CNT:  obj_count_q = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (cmd == CMD_LOAD) begin
          window_tab[entry_index] = '{x: rect_x, y: rect_y, w: rect_width, h: rect_height,
                                      vis: is_visible, cur: is_cursor};
        end else begin
          predict_zone(rect_x, rect_y, rect_width, rect_height, already_assigned);
        end
      end
    end
    pending <= expected_pieces.size();
  end

endmodule

>>> bench/testbench.sv
// Top of the damage zone clipper bench: clock, reset, stimulus, watchdog and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dzoc_pkg::*;

  // Index 3 lies past the register list; the block must ignore writes to it.
  localparam logic [1:0] REG_UNUSED = 2'd3;
  // Longest zone scan plus pipeline, with some margin; used as the settle pause.
  localparam int SETTLE_CYCLES = MAX_WINDOWS_DEF + 8;
  // Cycles with no word moving on any channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_COUNT = 12;
  localparam int WORDS_PER_PHASE = 28;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               cmd = CMD_LOAD;
  logic [3:0]         entry_index = '0;
  logic signed [15:0] rect_x = '0;
  logic signed [15:0] rect_y = '0;
  logic [DIM_W-1:0]   rect_width = '0;
  logic [DIM_W-1:0]   rect_height = '0;
  logic               is_visible = 1'b0;
  logic               is_cursor = 1'b0;
  logic               already_assigned = 1'b0;
  logic               strobe;
  logic [DIM_W-1:0]   piece_x;
  logic [DIM_W-1:0]   piece_y;
  logic [DIM_W-1:0]   piece_width;
  logic [DIM_W-1:0]   piece_height;
  logic [3:0]         window_index;
  logic               piece_valid;
  logic               last_piece;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = REG_CANVAS_W;
  logic [DIM_W-1:0]   cfg_data = '0;

  int fail_count;
  int pending;
  int pieces_checked;
  int sender_idle_pct = 0;
  int loads_sent = 0;
  int zones_sent = 0;
  int settings_used = 0;
  int idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  damage_zone_object_clipper_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .entry_index(entry_index), .rect_x(rect_x), .rect_y(rect_y),
    .rect_width(rect_width), .rect_height(rect_height), .is_visible(is_visible),
    .is_cursor(is_cursor), .already_assigned(already_assigned), .strobe(strobe),
    .piece_x(piece_x), .piece_y(piece_y), .piece_width(piece_width),
    .piece_height(piece_height), .window_index(window_index),
    .piece_valid(piece_valid), .last_piece(last_piece), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  damage_zone_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .entry_index(entry_index), .rect_x(rect_x), .rect_y(rect_y),
    .rect_width(rect_width), .rect_height(rect_height), .is_visible(is_visible),
    .is_cursor(is_cursor), .already_assigned(already_assigned), .strobe(strobe),
    .piece_x(piece_x), .piece_y(piece_y), .piece_width(piece_width),
    .piece_height(piece_height), .window_index(window_index),
    .piece_valid(piece_valid), .last_piece(last_piece), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .pieces_checked(pieces_checked)
  );

  // The watchdog restarts whenever any word moves on any channel. A hang, or a
  // zone whose pieces never all show up, lets it run out.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one command word and holds it until the block takes it. Random gaps
  // before the word are drawn from the current sender idle percentage. The word
  // is taken at the edge where start is high and busy is low, so busy is
  // sampled just after each edge, before the block updates it.
  task automatic send_word(logic c, logic [3:0] idx, logic signed [15:0] x,
                           logic signed [15:0] y, logic [DIM_W-1:0] w,
                           logic [DIM_W-1:0] h, logic vis, logic cur, logic asg);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    entry_index <= idx;
    rect_x <= x;
    rect_y <= y;
    rect_width <= w;
    rect_height <= h;
    is_visible <= vis;
    is_cursor <= cur;
    already_assigned <= asg;
    do @(posedge clk); while (busy);
    if (c == CMD_LOAD) loads_sent++;
    else zones_sent++;
  endtask

  // Drops start and waits until every expected piece has arrived and the block
  // reports idle, then waits out the settle pause. A load gives no piece, so
  // the pause covers anything still moving through the pipeline.
  task automatic wait_quiet();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Puts one register word on the configuration channel. The caller lowers
  // valid after the last word so that valid is never dropped and raised in
  // the same step.
  task automatic write_reg(logic [1:0] idx, logic [DIM_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Writes all three registers while the block is idle. Optionally pokes the
  // index past the list, which must change nothing.
  task automatic configure(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                           logic [DIM_W-1:0] cnt, bit poke_unused);
    wait_quiet();
    write_reg(REG_CANVAS_W, w);
    write_reg(REG_CANVAS_H, h);
    write_reg(REG_OBJ_CNT, cnt);
    if (poke_unused) write_reg(REG_UNUSED, 15'($urandom));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Coordinates mostly fall in a window set by the span of the phase,
  // with an occasional fully random value so every bit toggles.
  function automatic logic signed [15:0] rand_coord(int span);
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(0, span)) - span / 8);
  endfunction

  function automatic logic [DIM_W-1:0] rand_size(int span);
    if ($urandom_range(9) == 0) return 15'($urandom);
    return 15'($urandom_range(0, span));
  endfunction

  // One random phase: a fresh register setting, then a mix of table loads and
  // zones. Loads keep rewriting the table so later zones see new overlaps.
  task automatic run_phase(int p);
    logic [DIM_W-1:0] cw, ch, cnt;
    int               span;
    case (p % 6)
      0: begin cw = 15'd32767; ch = 15'd32767; end
      1: begin cw = 15'd1;     ch = 15'd1;     end
      2: begin cw = 15'($urandom_range(1, 200)); ch = 15'($urandom_range(1, 200)); end
      3: begin cw = 15'd0;     ch = 15'($urandom_range(0, 100)); end
      4: begin cw = 15'($urandom); ch = 15'($urandom); end
      default: begin cw = CANVAS_W_RST; ch = CANVAS_H_RST; end
    endcase
    case (p % 4)
      0: cnt = 15'(MAX_WINDOWS_DEF);
      1: cnt = 15'($urandom) | 15'd31;
      2: cnt = 15'($urandom_range(0, MAX_WINDOWS_DEF));
      default: cnt = 15'($urandom);
    endcase
    case (p % 3)
      0: span = 60;
      1: span = 400;
      default: span = 32767;
    endcase
    if (p < 4) sender_idle_pct = 23;
    else if (p < 8) sender_idle_pct = 48;
    else sender_idle_pct = 0;
    configure(cw, ch, cnt, p % 2 == 1);
    repeat (WORDS_PER_PHASE) begin
      if ($urandom_range(99) < 35) begin
        send_word(CMD_LOAD, 4'($urandom), rand_coord(span), rand_coord(span),
                  rand_size(span), rand_size(span), $urandom_range(99) < 80,
                  $urandom_range(9) == 0, 1'($urandom));
      end else begin
        send_word(CMD_ZONE, 4'($urandom), rand_coord(span), rand_coord(span),
                  rand_size(span), rand_size(span), 1'($urandom), 1'($urandom),
                  $urandom_range(99) < 15);
      end
    end
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    sender_idle_pct = 23;

    // Directed part on a 100 by 80 canvas. The count stays zero while the
    // table fills, so no zone can ever scan an entry that was never written.
    configure(15'd100, 15'd80, 15'd0, 1'b0);
    send_word(CMD_LOAD, 4'd0, 16'sd10, 16'sd10, 15'd20, 15'd20, 1'b1, 1'b0, 1'b0);
    // Crosses the top left corner of the canvas.
    send_word(CMD_LOAD, 4'd1, -16'sd20, -16'sd20, 15'd30, 15'd30, 1'b1, 1'b0, 1'b0);
    // Crosses the bottom right corner of the canvas.
    send_word(CMD_LOAD, 4'd2, 16'sd90, 16'sd70, 15'd50, 15'd50, 1'b1, 1'b0, 1'b0);
    // A hidden window and the cursor both cover everything and must be skipped.
    send_word(CMD_LOAD, 4'd3, 16'sd0, 16'sd0, 15'd100, 15'd80, 1'b0, 1'b0, 1'b0);
    send_word(CMD_LOAD, 4'd4, 16'sd0, 16'sd0, 15'd100, 15'd80, 1'b1, 1'b1, 1'b0);
    // Shares its left edge with the right edge of entry 0.
    send_word(CMD_LOAD, 4'd5, 16'sd30, 16'sd10, 15'd10, 15'd10, 1'b1, 1'b0, 1'b0);
    // Wholly right of the canvas.
    send_word(CMD_LOAD, 4'd6, 16'sd200, 16'sd10, 15'd10, 15'd10, 1'b1, 1'b0, 1'b0);
    // Field extremes: most negative corner and most positive corner.
    send_word(CMD_LOAD, 4'd7, -16'sd32768, -16'sd32768, 15'd32767, 15'd32767,
              1'b1, 1'b0, 1'b0);
    send_word(CMD_LOAD, 4'd8, 16'sd32767, 16'sd32767, 15'd32767, 15'd32767,
              1'b1, 1'b0, 1'b0);
    for (int i = 9; i < MAX_WINDOWS_DEF; i++) begin
      send_word(CMD_LOAD, 4'(i), 16'(i * 7), 16'(i * 5), 15'd10, 15'd10,
                1'(i % 2), i == 12, 1'b0);
    end
    configure(15'd100, 15'd80, 15'(MAX_WINDOWS_DEF), 1'b0);
    // Whole canvas zone, then the same zone already assigned.
    send_word(CMD_ZONE, 4'd0, 16'sd0, 16'sd0, 15'd100, 15'd80, 1'b0, 1'b0, 1'b0);
    send_word(CMD_ZONE, 4'd0, 16'sd0, 16'sd0, 15'd100, 15'd80, 1'b0, 1'b0, 1'b1);
    // Zone that only touches entry 0 at its corner: zero sized piece.
    send_word(CMD_ZONE, 4'd0, 16'sd30, 16'sd30, 15'd5, 15'd5, 1'b0, 1'b0, 1'b0);
    // Zone far from every window: only the empty end marker.
    send_word(CMD_ZONE, 4'd0, -16'sd30000, 16'sd0, 15'd10, 15'd10, 1'b0, 1'b0, 1'b0);
    send_word(CMD_ZONE, 4'd0, -16'sd32768, -16'sd32768, 15'd32767, 15'd32767,
              1'b0, 1'b0, 1'b0);
    send_word(CMD_ZONE, 4'd0, 16'sd32767, 16'sd32767, 15'd32767, 15'd32767,
              1'b0, 1'b0, 1'b0);
    send_word(CMD_ZONE, 4'd0, 16'sd0, 16'sd0, 15'd0, 15'd0, 1'b0, 1'b0, 1'b0);
    // Zero canvas and a count above the table size. Pieces starting at zero
    // or beyond are dropped; ones reaching in from negative space collapse.
    configure(15'd0, 15'd0, 15'd31, 1'b1);
    send_word(CMD_ZONE, 4'd0, 16'sd0, 16'sd0, 15'd100, 15'd80, 1'b0, 1'b0, 1'b0);
    send_word(CMD_ZONE, 4'd0, -16'sd20, -16'sd20, 15'd40, 15'd40, 1'b0, 1'b0, 1'b0);

    for (int p = 0; p < PHASE_COUNT; p++) run_phase(p);

    wait_quiet();
    $display("Covered %0d table loads and %0d zones over %0d register settings,",
             loads_sent, zones_sent, settings_used);
    $display("including zero, minimum and maximum canvases; %0d result words checked.",
             pieces_checked);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
